/* rtl/asas_pkg.sv */
// Shared types, widths and constants for the ADC scan averaging sequencer.
// Used by the controller, the datapath, the top level and the checker.
package asas_pkg;

  // Default sizing handed to the top-level parameters.
  localparam int unsigned CHANNELS_DEF     = 4;
  localparam int unsigned MAX_AVERAGES_DEF = 16;

  // Fixed field widths.
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned RATE_W     = 4;
  localparam int unsigned AVG_W      = 5;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned PERIOD_W   = 10;
  // Up to 31 kept 16-bit readings fit a 21-bit signed sum.
  localparam int unsigned SUM_W      = 21;
  localparam int unsigned DIV_CNT_W  = $clog2(SUM_W + 1);

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_COUNT = CFG_IDX_W'(1);

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic div_step;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic div_last;
    logic out_free;
  } dp_status_t;

  // Scan period in milliseconds: 1000 / rate, rate clamped to 1..10.
  function automatic logic [PERIOD_W-1:0] period_ms(input logic [RATE_W-1:0] rate);
    logic [PERIOD_W-1:0] p;
    case (rate)
      4'd0, 4'd1: p = 10'd1000;
      4'd2:       p = 10'd500;
      4'd3:       p = 10'd333;
      4'd4:       p = 10'd250;
      4'd5:       p = 10'd200;
      4'd6:       p = 10'd166;
      4'd7:       p = 10'd142;
      4'd8:       p = 10'd125;
      4'd9:       p = 10'd111;
      default:    p = 10'd100;
    endcase
    return p;
  endfunction

endpackage

/* rtl/asas_ctrl.sv */
// Controller state machine of the ADC scan averaging sequencer.
// Depends on asas_pkg; drives commands to asas_datapath.
module asas_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  asas_pkg::dp_status_t   status_i,
  output asas_pkg::ctrl_cmd_t    cmd_o
);
  import asas_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A request is taken only in idle; a tick that
  // closes a channel average runs the divider before its result is emitted.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/asas_datapath.sv */
// Datapath of the ADC scan averaging sequencer: configuration registers, scan
// state, input latch, iterative divider and output register. Depends on asas_pkg.
module asas_datapath #(
  parameter int unsigned Channels    = asas_pkg::CHANNELS_DEF,
  parameter int unsigned MaxAverages = asas_pkg::MAX_AVERAGES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  asas_pkg::ctrl_cmd_t                    cmd_i,
  output asas_pkg::dp_status_t                   status_o,
  input  logic                                   cfg_we_i,
  input  logic [asas_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [asas_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic [asas_pkg::TIME_W-1:0]            now_ms_i,
  input  logic                                   conv_ready_i,
  input  logic signed [asas_pkg::COUNT_W-1:0]    adc_counts_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic                                   start_conversion_o,
  output logic [asas_pkg::CHAN_W-1:0]            conversion_channel_o,
  output logic                                   average_valid_o,
  output logic [asas_pkg::CHAN_W-1:0]            average_channel_o,
  output logic signed [asas_pkg::COUNT_W-1:0]    average_value_o,
  output logic                                   cycle_done_o,
  output logic [asas_pkg::TIME_W-1:0]            cycle_elapsed_ms_o
);
  import asas_pkg::*;

  localparam int unsigned ChW = (Channels > 1) ? $clog2(Channels) : 1;
  localparam logic [ChW-1:0] LastCh = ChW'(Channels - 1);
  localparam logic [AVG_W-1:0] MaxAvgT =
    (MaxAverages >= (2 ** AVG_W) - 1) ? {AVG_W{1'b1}} : AVG_W'(MaxAverages);
  localparam logic [SUM_W-1:0] PosLim = SUM_W'(32767);
  localparam logic [SUM_W-1:0] NegLim = SUM_W'(32768);

  // Configuration registers.
  logic [RATE_W-1:0] rate_q;
  logic [AVG_W-1:0]  avg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_W'(1);
      avg_q  <= AVG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_RATE:   rate_q <= cfg_data_i[RATE_W-1:0];
        REG_AVERAGE_COUNT: avg_q  <= cfg_data_i[AVG_W-1:0];
        default: ;
      endcase
    end
  end

  // Latched request.
  logic [TIME_W-1:0]         now_q;
  logic                      ready_q;
  logic signed [COUNT_W-1:0] counts_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      now_q    <= now_ms_i;
      ready_q  <= conv_ready_i;
      counts_q <= adc_counts_i;
    end
  end

  // Scan state.
  logic                     converting_q, converting_d;
  logic [TIME_W-1:0]        next_due_q, next_due_d;
  logic [TIME_W-1:0]        cycle_start_q, cycle_start_d;
  logic [ChW-1:0]           ch_q, ch_d;
  logic                     settle_q, settle_d;
  logic [AVG_W-1:0]         kept_q, kept_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;

  // Clamped kept-read target and the running values after this reading.
  logic [AVG_W-1:0]        target;
  logic [AVG_W-1:0]        kept_inc;
  logic signed [SUM_W-1:0] sum_new;
  logic [SUM_W-1:0]        sum_bits;
  logic [SUM_W-1:0]        sum_mag;
  logic                    finishing;

  assign target    = (avg_q == '0) ? AVG_W'(1) : ((avg_q > MaxAvgT) ? MaxAvgT : avg_q);
  assign kept_inc  = (kept_q == {AVG_W{1'b1}}) ? kept_q : kept_q + AVG_W'(1);
  assign sum_new   = sum_q + SUM_W'(counts_q);
  assign sum_bits  = sum_new;
  assign sum_mag   = sum_bits[SUM_W-1] ? (~sum_bits + SUM_W'(1)) : sum_bits;
  assign finishing = converting_q && ready_q && !settle_q && (kept_inc >= target);

  // Restoring divider on the magnitude, one quotient bit per step.
  logic [AVG_W-1:0]     div_rem_q;
  logic [SUM_W-1:0]     div_quo_q;
  logic [AVG_W-1:0]     div_den_q;
  logic                 div_neg_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;
  logic [AVG_W:0]       div_shift;
  logic [AVG_W:0]       div_diff;
  logic                 div_ge;

  assign div_shift = {div_rem_q, div_quo_q[SUM_W-1]};
  assign div_diff  = div_shift - {1'b0, div_den_q};
  assign div_ge    = div_shift >= {1'b0, div_den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      div_cnt_q <= DIV_CNT_W'(SUM_W);
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      div_rem_q <= '0;
      div_quo_q <= sum_mag;
      div_den_q <= target;
      div_neg_q <= sum_bits[SUM_W-1];
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_ge ? div_diff[AVG_W-1:0] : div_shift[AVG_W-1:0];
      div_quo_q <= {div_quo_q[SUM_W-2:0], div_ge};
    end
  end

  // Signed quotient saturated to the 16-bit range.
  logic signed [COUNT_W-1:0] quo_sat;

  always_comb begin
    if (!div_neg_q) begin
      quo_sat = (div_quo_q > PosLim) ? COUNT_W'(32767) : div_quo_q[COUNT_W-1:0];
    end else begin
      quo_sat = (div_quo_q > NegLim) ? COUNT_W'(32768)
                                     : (~div_quo_q[COUNT_W-1:0] + COUNT_W'(1));
    end
  end

  // Outcome of the latched tick: next scan state and the result fields.
  logic                      t_start;
  logic [CHAN_W-1:0]         t_cchan;
  logic                      t_avg_valid;
  logic [CHAN_W-1:0]         t_achan;
  logic signed [COUNT_W-1:0] t_avg;
  logic                      t_done;
  logic [TIME_W-1:0]         t_elapsed;
  logic [ChW-1:0]            ch_inc;

  assign ch_inc = ch_q + ChW'(1);

  always_comb begin
    converting_d  = converting_q;
    next_due_d    = next_due_q;
    cycle_start_d = cycle_start_q;
    ch_d          = ch_q;
    settle_d      = settle_q;
    kept_d        = kept_q;
    sum_d         = sum_q;
    t_start       = 1'b0;
    t_cchan       = '0;
    t_avg_valid   = 1'b0;
    t_achan       = '0;
    t_avg         = '0;
    t_done        = 1'b0;
    t_elapsed     = '0;
    if (!converting_q) begin
      // Waiting: open a new scan cycle once the due time is reached.
      if (now_q >= next_due_q) begin
        cycle_start_d = now_q;
        ch_d          = '0;
        settle_d      = 1'b1;
        kept_d        = '0;
        sum_d         = '0;
        converting_d  = 1'b1;
        t_start       = 1'b1;
      end
    end else if (ready_q) begin
      if (settle_q) begin
        // Settle reading is discarded; request the first kept reading.
        settle_d = 1'b0;
        kept_d   = '0;
        sum_d    = '0;
        t_start  = 1'b1;
        t_cchan  = CHAN_W'(ch_q);
      end else begin
        sum_d  = sum_new;
        kept_d = kept_inc;
        if (!finishing) begin
          t_start = 1'b1;
          t_cchan = CHAN_W'(ch_q);
        end else begin
          t_avg_valid = 1'b1;
          t_achan     = CHAN_W'(ch_q);
          t_avg       = quo_sat;
          if (ch_q != LastCh) begin
            // Move on to the settle reading of the next channel.
            ch_d     = ch_inc;
            settle_d = 1'b1;
            kept_d   = '0;
            sum_d    = '0;
            t_start  = 1'b1;
            t_cchan  = CHAN_W'(ch_inc);
          end else begin
            // Last channel: close the cycle and schedule the next one.
            t_done       = 1'b1;
            t_elapsed    = now_q - cycle_start_q;
            next_due_d   = cycle_start_q + TIME_W'(period_ms(rate_q));
            converting_d = 1'b0;
            settle_d     = 1'b0;
            ch_d         = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      converting_q  <= 1'b0;
      next_due_q    <= '0;
      cycle_start_q <= '0;
      ch_q          <= '0;
      settle_q      <= 1'b0;
      kept_q        <= '0;
      sum_q         <= '0;
    end else if (cmd_i.commit) begin
      converting_q  <= converting_d;
      next_due_q    <= next_due_d;
      cycle_start_q <= cycle_start_d;
      ch_q          <= ch_d;
      settle_q      <= settle_d;
      kept_q        <= kept_d;
      sum_q         <= sum_d;
    end
  end

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      start_conversion_o   <= t_start;
      conversion_channel_o <= t_cchan;
      average_valid_o      <= t_avg_valid;
      average_channel_o    <= t_achan;
      average_value_o      <= t_avg;
      cycle_done_o         <= t_done;
      cycle_elapsed_ms_o   <= t_elapsed;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o.need_div = finishing;
  assign status_o.div_last = (div_cnt_q == DIV_CNT_W'(1));
  assign status_o.out_free = !out_valid_q || !out_stall_i;

endmodule

/* rtl/adc_scan_averaging_sequencer.sv */
// ADC scan averaging sequencer, top level. Depends on asas_pkg, asas_ctrl, asas_datapath.
// Each request is latched and evaluated; its result is registered on commit, once the
// output is free, and the next request is taken after that commit. A tick that closes a
// channel average first runs the 21 one-bit steps of the divider. One result per request.
// Reset (asynchronous, active low) clears the scan state and output valid and sets both
// configuration registers to 1; there is no clearing pass.
module adc_scan_averaging_sequencer #(
  parameter int unsigned Channels    = asas_pkg::CHANNELS_DEF,
  parameter int unsigned MaxAverages = asas_pkg::MAX_AVERAGES_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [asas_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [asas_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [asas_pkg::TIME_W-1:0]            now_ms_i,
  input  logic                                   conv_ready_i,
  input  logic signed [asas_pkg::COUNT_W-1:0]    adc_counts_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   start_conversion_o,
  output logic [asas_pkg::CHAN_W-1:0]            conversion_channel_o,
  output logic                                   average_valid_o,
  output logic [asas_pkg::CHAN_W-1:0]            average_channel_o,
  output logic signed [asas_pkg::COUNT_W-1:0]    average_value_o,
  output logic                                   cycle_done_o,
  output logic [asas_pkg::TIME_W-1:0]            cycle_elapsed_ms_o
);
  import asas_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencing of each request.
  asas_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Scan state, divider and output register.
  asas_datapath #(
    .Channels    (Channels),
    .MaxAverages (MaxAverages)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .now_ms_i             (now_ms_i),
    .conv_ready_i         (conv_ready_i),
    .adc_counts_i         (adc_counts_i),
    .out_stall_i          (out_stall_i),
    .out_valid_o          (out_valid_o),
    .start_conversion_o   (start_conversion_o),
    .conversion_channel_o (conversion_channel_o),
    .average_valid_o      (average_valid_o),
    .average_channel_o    (average_channel_o),
    .average_value_o      (average_value_o),
    .cycle_done_o         (cycle_done_o),
    .cycle_elapsed_ms_o   (cycle_elapsed_ms_o)
  );

endmodule

/* rtl/asas_checker.sv */
// Port-level checker for the ADC scan averaging sequencer, and its bind.
// Depends on asas_pkg and adc_scan_averaging_sequencer.
module asas_props (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   cfg_we_i,
  input logic [asas_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input logic [asas_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic [asas_pkg::TIME_W-1:0]            now_ms_i,
  input logic                                   conv_ready_i,
  input logic signed [asas_pkg::COUNT_W-1:0]    adc_counts_i,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic                                   start_conversion_o,
  input logic [asas_pkg::CHAN_W-1:0]            conversion_channel_o,
  input logic                                   average_valid_o,
  input logic [asas_pkg::CHAN_W-1:0]            average_channel_o,
  input logic signed [asas_pkg::COUNT_W-1:0]    average_value_o,
  input logic                                   cycle_done_o,
  input logic [asas_pkg::TIME_W-1:0]            cycle_elapsed_ms_o
);

  // A cycle closes only on a channel average and never requests a conversion.
  a_done_with_average: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cycle_done_o |-> average_valid_o && !start_conversion_o)
    else $error("cycle_done without a closing average");

  // Fields without their flag read as zero.
  a_unused_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (start_conversion_o || conversion_channel_o == '0) &&
      (average_valid_o || (average_channel_o == '0 && average_value_o == '0)) &&
      (cycle_done_o || cycle_elapsed_ms_o == '0))
    else $error("result field set without its flag");

  // One request at a time: after a request is taken the input stalls.
  a_stall_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second request taken back to back");

  // A stalled result stays and holds its fields.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(start_conversion_o) &&
      $stable(conversion_channel_o) && $stable(average_valid_o) &&
      $stable(average_channel_o) && $stable(average_value_o) &&
      $stable(cycle_done_o) && $stable(cycle_elapsed_ms_o))
    else $error("stalled result changed");

endmodule

bind adc_scan_averaging_sequencer asas_props u_asas_props (.*);
